[rtl/core/song_position_and_sample_timer_top_macros.svh]
// Assertion helpers shared by the timer RTL.
`ifndef SONG_POSITION_AND_SAMPLE_TIMER_TOP_MACROS_SVH
`define SONG_POSITION_AND_SAMPLE_TIMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spst_pkg.sv]
package spst_pkg;

    localparam int unsigned TEMPO_SCALE        = 441;
    localparam int unsigned DIV_SCALE          = 10000;
    localparam int unsigned QUARTERS_PER_WHOLE = 4;
    localparam logic [15:0] TPQ_RESET          = 16'd96;

    localparam int unsigned DIVIDEND_W = 56;
    localparam int unsigned DIVISOR_W  = 30;
    localparam int unsigned STEP_W     = 6;

    localparam logic [STEP_W-1:0] TICK_STEPS = 6'd25;
    localparam logic [STEP_W-1:0] QPB_STEPS  = 6'd10;
    localparam logic [STEP_W-1:0] BEAT_STEPS = 6'd26;
    localparam logic [STEP_W-1:0] SAMP_STEPS = 6'd56;

    typedef struct packed {
        logic [23:0] elapsed_ticks;
        logic [7:0]  sig_numerator;
        logic [7:0]  sig_denominator;
        logic [23:0] ticks_to_next;
        logic [23:0] quarter_usecs;
        logic        song_ended;
    } in_item_t;

    typedef struct packed {
        logic [31:0] samples_to_next;
        logic [15:0] bar_number;
        logic [9:0]  beat_in_bar;
        logic [15:0] tick_in_beat;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_QPB,
        ST_BEAT,
        ST_SAMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [STEP_W-1:0]     steps;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

[rtl/core/spst_div.sv]
`include "song_position_and_sample_timer_top_macros.svh"

// Restoring divider, one quotient bit per cycle. Dividend is left aligned;
// after N steps the quotient sits in the low N bits.
module spst_div (
    input  logic                clk,
    input  logic                rst_n,
    input  spst_pkg::div_req_t  req,
    output spst_pkg::div_rsp_t  rsp
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [spst_pkg::STEP_W-1:0]        cnt_reg;
    logic [spst_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [spst_pkg::DIVIDEND_W-1:0]    dq_reg;
    logic [spst_pkg::DIVISOR_W-1:0]     dvs_reg;

    logic [spst_pkg::DIVISOR_W:0]       rem_sh;
    logic [spst_pkg::DIVISOR_W:0]       rem_sub;
    logic                               ge;
    logic [spst_pkg::DIVISOR_W-1:0]     rem_step;

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[spst_pkg::DIVIDEND_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        rem_step = ge ? rem_sub[spst_pkg::DIVISOR_W-1:0] : rem_sh[spst_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != 1);
            done_reg <= (cnt_reg == 1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dq_reg  <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dq_reg  <= {dq_reg[spst_pkg::DIVIDEND_W-2:0], ge};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

    `SPST_ASSERT_IMP(a_no_restart_busy, req.start, !busy_reg, "divider started while busy")
    `SPST_ASSERT_IMP(a_busy_has_count, busy_reg, cnt_reg != '0, "divider busy with zero count")

endmodule

[rtl/core/song_position_and_sample_timer_top.sv]
// Transactions are handled one at a time: input stalls from acceptance until the result
// is emitted, while the single shared bit-serial divider runs 25+10+26+56 steps (the
// last 56 are skipped at song end).
// A finished result waits in an output register; the next input is taken meanwhile.
// Reset (async, rst_n low): ticks_per_quarter = 96, song position and
// remainder accumulator cleared, no result pending.
`include "song_position_and_sample_timer_top_macros.svh"

module song_position_and_sample_timer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  spst_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output spst_pkg::out_item_t out_item,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    spst_pkg::state_t    state_reg;
    spst_pkg::state_t    state_next;
    spst_pkg::div_req_t  div_req;
    spst_pkg::div_rsp_t  div_rsp;

    spst_pkg::in_item_t  in_hold_reg;
    spst_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;

    logic [15:0] tpq_reg;
    logic [15:0] tick_acc_reg;
    logic [9:0]  beat_acc_reg;
    logic [15:0] bar_acc_reg;
    logic [31:0] rem_acc_reg;

    logic [31:0] tempo_reg;
    logic [55:0] prod_reg;
    logic [29:0] dscale_reg;
    logic [24:0] tq_reg;
    logic [31:0] samples_reg;

    logic        in_accept;
    logic        out_free;
    logic [15:0] tpq_eff;
    logic [7:0]  den_eff;
    logic [24:0] t_sum;
    logic [25:0] b_sum;
    logic [9:0]  qpb_eff;
    logic [32:0] tempo_full;
    logic [32:0] r_sum;
    logic [31:0] samp_val;

    spst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != spst_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        tpq_eff    = (tpq_reg == '0) ? 16'd1 : tpq_reg;
        den_eff    = (in_hold_reg.sig_denominator == '0) ? 8'd1 : in_hold_reg.sig_denominator;
        t_sum      = {1'b0, in_item.elapsed_ticks} + {9'b0, tick_acc_reg};
        b_sum      = {1'b0, tq_reg} + {16'b0, beat_acc_reg};
        qpb_eff    = (div_rsp.quotient[9:0] == '0) ? 10'd1 : div_rsp.quotient[9:0];
        tempo_full = {9'b0, in_item.quarter_usecs} * 33'(spst_pkg::TEMPO_SCALE);
        r_sum      = {1'b0, rem_acc_reg} + {3'b0, div_rsp.remainder};
        if ((|div_rsp.quotient[55:32]) || (&div_rsp.quotient[31:0]))
            samp_val = '1;
        else
            samp_val = div_rsp.quotient[31:0] + {31'b0, r_sum[32]};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spst_pkg::ST_IDLE:
                if (in_accept)
                    state_next = spst_pkg::ST_TICK;
            spst_pkg::ST_TICK:
                if (div_rsp.done)
                    state_next = spst_pkg::ST_QPB;
            spst_pkg::ST_QPB:
                if (div_rsp.done)
                    state_next = spst_pkg::ST_BEAT;
            spst_pkg::ST_BEAT:
                if (div_rsp.done)
                    state_next = in_hold_reg.song_ended ? spst_pkg::ST_EMIT : spst_pkg::ST_SAMP;
            spst_pkg::ST_SAMP:
                if (div_rsp.done)
                    state_next = spst_pkg::ST_EMIT;
            spst_pkg::ST_EMIT:
                if (out_free)
                    state_next = spst_pkg::ST_IDLE;
            default:
                state_next = spst_pkg::ST_IDLE;
        endcase
    end

    // divider launch
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            spst_pkg::ST_IDLE:
            begin
                div_req.start    = in_accept;
                div_req.steps    = spst_pkg::TICK_STEPS;
                div_req.dividend = {t_sum, 31'b0};
                div_req.divisor  = {14'b0, tpq_eff};
            end
            spst_pkg::ST_TICK:
            begin
                div_req.start    = div_rsp.done;
                div_req.steps    = spst_pkg::QPB_STEPS;
                div_req.dividend = {in_hold_reg.sig_numerator, 2'b00, 46'b0};
                div_req.divisor  = {22'b0, den_eff};
            end
            spst_pkg::ST_QPB:
            begin
                div_req.start    = div_rsp.done;
                div_req.steps    = spst_pkg::BEAT_STEPS;
                div_req.dividend = {b_sum, 30'b0};
                div_req.divisor  = {20'b0, qpb_eff};
            end
            spst_pkg::ST_BEAT:
            begin
                div_req.start    = div_rsp.done && !in_hold_reg.song_ended;
                div_req.steps    = spst_pkg::SAMP_STEPS;
                div_req.dividend = prod_reg;
                div_req.divisor  = dscale_reg;
            end
            default:
                div_req = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            tpq_reg       <= spst_pkg::TPQ_RESET;
            tick_acc_reg  <= '0;
            beat_acc_reg  <= '0;
            bar_acc_reg   <= '0;
            rem_acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                tpq_reg <= cfg_wr_data;
            if (state_reg == spst_pkg::ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == spst_pkg::ST_TICK && div_rsp.done)
                tick_acc_reg <= div_rsp.remainder[15:0];
            if (state_reg == spst_pkg::ST_BEAT && div_rsp.done)
            begin
                bar_acc_reg  <= bar_acc_reg + div_rsp.quotient[15:0];
                beat_acc_reg <= div_rsp.remainder[9:0];
            end
            if (state_reg == spst_pkg::ST_SAMP && div_rsp.done)
                rem_acc_reg <= r_sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_hold_reg <= in_item;
            tempo_reg   <= tempo_full[31:0];
        end
        if (state_reg == spst_pkg::ST_QPB)
        begin
            prod_reg   <= {32'b0, in_hold_reg.ticks_to_next} * {24'b0, tempo_reg};
            dscale_reg <= {14'b0, tpq_eff} * 30'(spst_pkg::DIV_SCALE);
        end
        if (state_reg == spst_pkg::ST_TICK && div_rsp.done)
            tq_reg <= div_rsp.quotient[24:0];
        if (state_reg == spst_pkg::ST_BEAT && div_rsp.done && in_hold_reg.song_ended)
            samples_reg <= '1;
        if (state_reg == spst_pkg::ST_SAMP && div_rsp.done)
            samples_reg <= samp_val;
        if (state_reg == spst_pkg::ST_EMIT && out_free)
        begin
            out_item_reg.samples_to_next <= samples_reg;
            out_item_reg.bar_number      <= bar_acc_reg;
            out_item_reg.beat_in_bar     <= beat_acc_reg;
            out_item_reg.tick_in_beat    <= tick_acc_reg;
        end
    end

    `SPST_ASSERT_NEXT(a_accept_starts_tick, in_valid && !in_stall,
        state_reg == spst_pkg::ST_TICK, "transaction did not start tick fold")
    `SPST_ASSERT_IMP(a_done_in_div_state, div_rsp.done,
        state_reg == spst_pkg::ST_TICK || state_reg == spst_pkg::ST_QPB ||
        state_reg == spst_pkg::ST_BEAT || state_reg == spst_pkg::ST_SAMP,
        "divider done outside a divide step")
    `SPST_ASSERT_NEXT(a_emit_waits_for_room,
        state_reg == spst_pkg::ST_EMIT && out_valid_reg && out_stall,
        state_reg == spst_pkg::ST_EMIT && out_valid_reg, "result overwrote a stalled transaction")
    `SPST_ASSERT_NEXT(a_song_end_all_ones,
        state_reg == spst_pkg::ST_BEAT && div_rsp.done && in_hold_reg.song_ended,
        state_reg == spst_pkg::ST_EMIT && samples_reg == '1, "song end did not give all ones")

endmodule
